// ===== hdl/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg
// Types and constants shared by the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

  // Field widths and fixed-point formats
  localparam int CHAN_W    = 8;
  localparam int HUE_W     = 15;
  localparam int SAT_W     = 13;
  localparam int HUE_FRAC  = 6;
  localparam int SAT_FRAC  = 12;

  // 60 and 360 degrees in hue units
  localparam int HUE_SIXTH = 60 << HUE_FRAC;
  localparam int HUE_FULL  = 360 << HUE_FRAC;

  // Divider geometry: dividend below 2^20, quotient below 2^13 for both divides
  localparam int DIVD_W    = CHAN_W + SAT_FRAC;
  localparam int QUOT_W    = SAT_W;
  localparam int QIDX_W    = $clog2(QUOT_W);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_t;

  // Channel that holds the maximum
  typedef enum logic [2:0] {
    SEC_RED   = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE  = 3'b100
  } sector_t;

  // One lane of a restoring divider in flight
  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [CHAN_W-1:0] divisor;
    logic [QUOT_W-1:0] quot;
  } div_lane_t;

  // Data that rides alongside the dividers
  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              gray;
    logic [CHAN_W-1:0] brightness;
  } side_t;

  // One restoring step: try the divisor at bit position shift
  function automatic div_lane_t div_step(input div_lane_t lane,
                                         input logic [QIDX_W-1:0] shift);
    logic [DIVD_W-1:0] trial;
    div_lane_t         res;
    trial = DIVD_W'(lane.divisor) << shift;
    res   = lane;
    if (lane.rem >= trial) begin
      res.rem         = lane.rem - trial;
      res.quot[shift] = 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== hdl/rgb_to_hsv_converter_top.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB pixel to hue, saturation and value converter.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the pixel channel carries one 8-bit RGB pixel; it is taken
//   at a clock edge where pixel_valid is high and pixel_stall is low.
//   The result channel carries hue (1/64 degree), saturation (4096 = 1.0)
//   and brightness (largest channel) under result_valid / result_stall.
//   From accept to result_valid a pixel passes two front stages,
//   thirteen divider stages (one quotient bit each for both divides) and
//   one output stage. Throughput is one pixel per cycle while the receiver
//   does not stall, set by the fully pipelined dividers.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   pixel_stall is raised; nothing is dropped or repeated. Bubbles are not
//   squeezed out while stalled.
//   Synchronous reset clears all valid bits; the block is ready as soon as
//   reset is released.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  output logic            pixel_stall,
  input  hsv_pkg::pixel_t pixel,
  output logic            result_valid,
  input  logic            result_stall,
  output hsv_pkg::hsv_t   result
);
  import hsv_pkg::*;

  logic      en;
  logic      prep_valid;
  div_lane_t prep_sat;
  div_lane_t prep_hue;
  side_t     prep_side;
  logic      div_valid;
  div_lane_t div_sat;
  div_lane_t div_hue;
  side_t     div_side;

  // Hold every stage while a result waits on a stalled receiver
  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;

  hsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel_valid),
    .pix       (pixel),
    .out_valid (prep_valid),
    .sat_lane  (prep_sat),
    .hue_lane  (prep_hue),
    .side      (prep_side)
  );

  hsv_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_valid),
    .sat_in    (prep_sat),
    .hue_in    (prep_hue),
    .side_in   (prep_side),
    .out_valid (div_valid),
    .sat_out   (div_sat),
    .hue_out   (div_hue),
    .side_out  (div_side)
  );

  logic signed [HUE_W:0] offset;
  logic signed [HUE_W:0] q;
  logic signed [HUE_W:0] hue_s;
  hsv_t                  res_next;

  // Add sector offset to the signed quotient, wrap negative hue, zero gray pixels
  always_comb begin
    case (div_side.sector)
      SEC_RED:   offset = '0;
      SEC_GREEN: offset = (HUE_W+1)'(2 * HUE_SIXTH);
      SEC_BLUE:  offset = (HUE_W+1)'(4 * HUE_SIXTH);
      default:   offset = '0;
    endcase
    q     = $signed((HUE_W+1)'(div_hue.quot));
    hue_s = div_side.neg ? (offset - q) : (offset + q);
    if (hue_s < 0) hue_s = hue_s + (HUE_W+1)'(HUE_FULL);
    res_next.brightness = div_side.brightness;
    if (div_side.gray) begin
      res_next.hue        = '0;
      res_next.saturation = '0;
    end else begin
      res_next.hue        = hue_s[HUE_W-1:0];
      res_next.saturation = div_sat.quot;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= div_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule

// ===== hdl/hsv_prep.sv =====
// ----------------------------------------------------------------------------
// hsv_prep
// Two front stages: find max, min and sector, then form delta, the signed
// channel difference and both divider dividends.
// ----------------------------------------------------------------------------
module hsv_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  hsv_pkg::pixel_t   pix,
  output logic              out_valid,
  output hsv_pkg::div_lane_t sat_lane,
  output hsv_pkg::div_lane_t hue_lane,
  output hsv_pkg::side_t    side
);
  import hsv_pkg::*;

  logic              a_valid;
  pixel_t            a_pix;
  logic [CHAN_W-1:0] a_max;
  logic [CHAN_W-1:0] a_min;
  sector_t           a_sector;

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  sector_t           sec;

  // Largest and smallest channel, red wins ties over green, green over blue
  always_comb begin
    mx = (pix.red > pix.green) ? pix.red : pix.green;
    mn = (pix.red < pix.green) ? pix.red : pix.green;
    if (pix.blue > mx) mx = pix.blue;
    if (pix.blue < mn) mn = pix.blue;
    if (pix.red >= mx) begin
      sec = SEC_RED;
    end else if (pix.green >= mx) begin
      sec = SEC_GREEN;
    end else begin
      sec = SEC_BLUE;
    end
  end

  // Stage A valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_pix    <= pix;
      a_max    <= mx;
      a_min    <= mn;
      a_sector <= sec;
    end
  end

  logic [CHAN_W-1:0]        delta;
  logic signed [CHAN_W:0]   diff;
  logic [CHAN_W-1:0]        mag;
  logic [DIVD_W-1:0]        prod;

  // Difference of the two other channels, split into sign and magnitude; also delta and the hue dividend
  always_comb begin
    delta = a_max - a_min;
    case (a_sector)
      SEC_RED:   diff = $signed({1'b0, a_pix.green}) - $signed({1'b0, a_pix.blue});
      SEC_GREEN: diff = $signed({1'b0, a_pix.blue})  - $signed({1'b0, a_pix.red});
      SEC_BLUE:  diff = $signed({1'b0, a_pix.red})   - $signed({1'b0, a_pix.green});
      default:   diff = '0;
    endcase
    mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    prod = DIVD_W'(mag) * DIVD_W'(HUE_SIXTH);
  end

  // Stage B valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  // Stage B payload: load both divider lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sat_lane.rem     <= {delta, {SAT_FRAC{1'b0}}};
      sat_lane.divisor <= a_max;
      sat_lane.quot    <= '0;
      hue_lane.rem     <= prod;
      hue_lane.divisor <= delta;
      hue_lane.quot    <= '0;
      side.sector      <= a_sector;
      side.neg         <= diff[CHAN_W];
      side.gray        <= (delta == '0);
      side.brightness  <= a_max;
    end
  end

endmodule

// ===== hdl/hsv_div_pipe.sv =====
// ----------------------------------------------------------------------------
// hsv_div_pipe
// Pipelined restoring dividers for saturation and hue, one quotient bit per
// stage for both lanes, with side data and valid carried alongside.
// ----------------------------------------------------------------------------
module hsv_div_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  hsv_pkg::div_lane_t sat_in,
  input  hsv_pkg::div_lane_t hue_in,
  input  hsv_pkg::side_t     side_in,
  output logic               out_valid,
  output hsv_pkg::div_lane_t sat_out,
  output hsv_pkg::div_lane_t hue_out,
  output hsv_pkg::side_t     side_out
);
  import hsv_pkg::*;

  logic      valid [QUOT_W];
  div_lane_t sat   [QUOT_W];
  div_lane_t hue   [QUOT_W];
  side_t     side  [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic      prev_valid;
    div_lane_t prev_sat;
    div_lane_t prev_hue;
    side_t     prev_side;

    if (k == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_sat   = sat_in;
      assign prev_hue   = hue_in;
      assign prev_side  = side_in;
    end else begin : g_next
      assign prev_valid = valid[k-1];
      assign prev_sat   = sat[k-1];
      assign prev_hue   = hue[k-1];
      assign prev_side  = side[k-1];
    end

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= prev_valid;
      end
    end

    // Resolve quotient bit QUOT_W-1-k in both lanes
    always_ff @(posedge clk) begin
      if (en) begin
        sat[k]  <= div_step(prev_sat, QIDX_W'(QUOT_W - 1 - k));
        hue[k]  <= div_step(prev_hue, QIDX_W'(QUOT_W - 1 - k));
        side[k] <= prev_side;
      end
    end
  end

  assign out_valid = valid[QUOT_W-1];
  assign sat_out   = sat[QUOT_W-1];
  assign hue_out   = hue[QUOT_W-1];
  assign side_out  = side[QUOT_W-1];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB to HSV pixel converter. A driver feeds
// pixel requests from a queue and a monitor checks every result, in order,
// against a behavioral model of the conversion held in this file. Both sides
// idle at random, the receiver holds off once long enough to back the
// pipeline up, and the sender drains the block completely between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import hsv_pkg::*;

  localparam int IDLE_PCT     = 26;
  localparam int CALM_FIRST   = 1500;
  localparam int CALM_LAST    = 2300;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 250;
  localparam int FIRST_BATCH  = 800;
  localparam int SECOND_BATCH = 750;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 100;

  logic   clk          = 1'b0;
  logic   rst          = 1'b1;
  logic   pixel_valid  = 1'b0;
  logic   pixel_stall;
  pixel_t pixel        = '0;
  logic   result_valid;
  logic   result_stall = 1'b0;
  hsv_t   result;

  pixel_t pixel_queue[$];
  hsv_t   expected_hsv[$];
  int     mismatch_count = 0;
  int     results_seen   = 0;
  int     cycle_count    = 0;
  int     hold_cycles    = 0;
  logic   hold_done      = 1'b0;
  logic   calm;

  rgb_to_hsv_converter_top uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stretch of the run where neither side idles
  assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

  // Count and print one mismatch
  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Convert one pixel to hue, saturation and value
  function automatic hsv_t convert_pixel(input pixel_t px);
    int   r, g, b;
    int   top, bottom, spread;
    int   angle, sat;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top    = (r > g) ? r : g;
    bottom = (r < g) ? r : g;
    if (b > top) top = b;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    angle = 0;
    sat   = 0;
    // gray pixels keep hue and saturation at zero
    if (spread != 0) begin
      sat = (spread << SAT_FRAC) / top;
      // red wins a tie with green, green wins a tie with blue
      if (r == top) begin
        angle = (HUE_SIXTH * (g - b)) / spread;
      end else if (g == top) begin
        angle = 2 * HUE_SIXTH + (HUE_SIXTH * (b - r)) / spread;
      end else begin
        angle = 4 * HUE_SIXTH + (HUE_SIXTH * (r - g)) / spread;
      end
      // wrap negative hue into one full turn
      if (angle < 0) angle += HUE_FULL;
    end
    res.hue        = HUE_W'(angle);
    res.saturation = SAT_W'(sat);
    res.brightness = CHAN_W'(top);
    return res;
  endfunction

  function automatic pixel_t make_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red   = CHAN_W'(r);
    px.green = CHAN_W'(g);
    px.blue  = CHAN_W'(b);
    return px;
  endfunction

  // Pick one channel value: zero, full scale or anything
  function automatic int edge_channel();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(255);
  endfunction

  // Random pixel, weighted toward grays, tied maxima and extreme channels
  function automatic pixel_t random_pixel();
    int kind, hi, lo, odd;
    kind = $urandom_range(99);
    hi   = $urandom_range(255);
    lo   = $urandom_range(hi);
    odd  = $urandom_range(2);
    if (kind < 10) return make_pixel(hi, hi, hi);
    if (kind < 20) begin
      if (odd == 0) return make_pixel(lo, hi, hi);
      if (odd == 1) return make_pixel(hi, lo, hi);
      return make_pixel(hi, hi, lo);
    end
    if (kind < 28) return make_pixel(edge_channel(), edge_channel(), edge_channel());
    return make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endfunction

  // Check one accepted result against the oldest expectation
  task automatic check_result(input hsv_t got);
    hsv_t want;
    results_seen++;
    if (expected_hsv.size() == 0) begin
      report_mismatch($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                got.hue, got.saturation, got.brightness));
      return;
    end
    want = expected_hsv.pop_front();
    if (got.hue !== want.hue)
      report_mismatch($sformatf("result %0d hue %0d, want %0d",
                                results_seen, got.hue, want.hue));
    if (got.saturation !== want.saturation)
      report_mismatch($sformatf("result %0d saturation %0d, want %0d",
                                results_seen, got.saturation, want.saturation));
    if (got.brightness !== want.brightness)
      report_mismatch($sformatf("result %0d brightness %0d, want %0d",
                                results_seen, got.brightness, want.brightness));
  endtask

  // Driver: record accepted requests, offer the next pixel when the slot frees
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) expected_hsv.push_back(convert_pixel(pixel));
      if (!pixel_valid || !pixel_stall) begin
        if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          pixel       <= pixel_queue.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: start once, then count the stretch down in cycles
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done   <= 1'b1;
      hold_cycles <= HOLD_LEN;
    end
  end

  // Monitor: check results, stall at random or while the long hold-off runs
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (hold_cycles > 0) begin
        result_stall <= 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Wait until every request is accepted and every result has come back
  task automatic drain();
    while (pixel_queue.size() != 0 || pixel_valid || expected_hsv.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus
  initial begin
    // black, white, gray
    pixel_queue.push_back(make_pixel(0, 0, 0));
    pixel_queue.push_back(make_pixel(255, 255, 255));
    pixel_queue.push_back(make_pixel(128, 128, 128));
    // primaries
    pixel_queue.push_back(make_pixel(255, 0, 0));
    pixel_queue.push_back(make_pixel(0, 255, 0));
    pixel_queue.push_back(make_pixel(0, 0, 255));
    // tied maxima
    pixel_queue.push_back(make_pixel(255, 255, 0));
    pixel_queue.push_back(make_pixel(0, 255, 255));
    pixel_queue.push_back(make_pixel(255, 0, 255));
    pixel_queue.push_back(make_pixel(1, 0, 1));
    pixel_queue.push_back(make_pixel(1, 1, 0));
    pixel_queue.push_back(make_pixel(0, 1, 1));
    // wrap of negative hue, small and near full turn
    pixel_queue.push_back(make_pixel(255, 0, 1));
    pixel_queue.push_back(make_pixel(255, 0, 254));
    pixel_queue.push_back(make_pixel(255, 1, 0));
    // smallest spreads and smallest maxima
    pixel_queue.push_back(make_pixel(1, 0, 0));
    pixel_queue.push_back(make_pixel(0, 0, 1));
    pixel_queue.push_back(make_pixel(255, 254, 254));
    pixel_queue.push_back(make_pixel(254, 255, 253));
    // one of each sector
    pixel_queue.push_back(make_pixel(200, 100, 50));
    pixel_queue.push_back(make_pixel(50, 200, 100));
    pixel_queue.push_back(make_pixel(100, 50, 200));
    pixel_queue.push_back(make_pixel(170, 85, 0));
    pixel_queue.push_back(make_pixel(85, 170, 255));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    drain();
    repeat (FIRST_BATCH) pixel_queue.push_back(random_pixel());
    drain();
    repeat (SECOND_BATCH) pixel_queue.push_back(random_pixel());
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_converter_top.f =====
hdl/hsv_pkg.sv
hdl/hsv_prep.sv
hdl/hsv_div_pipe.sv
hdl/rgb_to_hsv_converter_top.sv
tb/tb_top.sv
